// ----- design/mspl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mspl_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_CLOSED_LOOP_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRACKED_SPEED_RPM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_LOOP_COMMAND  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_OFFSET     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P             = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I             = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D             = 3'd6;

	// Shared multiplier geometry.
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 24;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Fixed-point coefficients (scaled by 2^16 unless noted).
	localparam logic signed [MUL_B_W-1:0] K_RPM      = 24'sd39114;   // rad/s to rpm
	localparam logic signed [MUL_B_W-1:0] K_RAD      = 24'sd109807;  // rpm to rad/s
	localparam logic signed [MUL_B_W-1:0] K_DT       = 24'sd10486;   // dt of 0.01 s
	localparam logic signed [MUL_B_W-1:0] K_ALPHA_D  = 24'sd983000;  // 100 * 9830
	localparam logic signed [MUL_B_W-1:0] K_ALPHA_O  = 24'sd55706;   // 1 - alpha
	localparam logic signed [MUL_B_W-1:0] K_DIV25    = 24'sd2684355; // 2^26 / 25, rounded up
	localparam logic signed [MUL_B_W-1:0] K_DIV3     = 24'sd87382;   // 2^18 / 3, rounded up

	localparam logic [15:0] VOLT_MAX      = 16'd49152;
	localparam logic [15:0] VOLT_NEAR_MAX = 16'd49103;
	localparam logic [14:0] DUTY_MAX      = 15'd25600;
	localparam logic [14:0] CMD_NEAR_MAX  = 15'd25575;
	localparam logic [25:0] ERR_FAULT     = 26'd16000;
	localparam logic [25:0] ERR_WARN      = 26'd1600;

	localparam logic [1:0] HEALTH_NORMAL = 2'd0;
	localparam logic [1:0] HEALTH_TRACK  = 2'd1;
	localparam logic [1:0] HEALTH_FAULT  = 2'd2;

	typedef struct packed {
		logic               closed_loop;
		logic [19:0]        tracked;
		logic [14:0]        command;
		logic signed [16:0] offset;
		logic [15:0]        gain_p;
		logic [15:0]        gain_i;
		logic [15:0]        gain_d;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_RPM_MUL,
		OP_TGT_MUL,
		OP_OPEN_MUL,
		OP_ZERO,
		OP_ERR,
		OP_IINC_MUL,
		OP_DF1_MUL,
		OP_DF2_MUL,
		OP_DFP_MUL,
		OP_I_MUL,
		OP_D_MUL,
		OP_PID,
		OP_OPEN_VOLTS,
		OP_DRIVE,
		OP_DUTY_MUL
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   load_in;
		logic   load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic closed_loop;
		logic invalid;
	} dp_stat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RPM,
		ST_TGT,
		ST_OPEN,
		ST_ZERO,
		ST_ERR,
		ST_IINC,
		ST_DF1,
		ST_DF2,
		ST_DFP,
		ST_IMUL,
		ST_DMUL,
		ST_PID,
		ST_OVOLTS,
		ST_DRIVE,
		ST_DUTY,
		ST_FINISH
	} ctl_state_t;

endpackage

`default_nettype wire

// ----- design/mspl_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mspl_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [mspl_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [mspl_pkg::CFG_DATA_W-1:0] wr_data,
	output mspl_pkg::cfg_t                       cfg
);

	mspl_pkg::cfg_t cfg_q;

	// Writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				mspl_pkg::REG_CLOSED_LOOP_ENABLE: cfg_q.closed_loop <= wr_data[0];
				mspl_pkg::REG_TRACKED_SPEED_RPM:  cfg_q.tracked     <= wr_data[19:0];
				mspl_pkg::REG_OPEN_LOOP_COMMAND:  cfg_q.command     <= wr_data[14:0];
				mspl_pkg::REG_VOLTAGE_OFFSET:     cfg_q.offset      <= $signed(wr_data[16:0]);
				mspl_pkg::REG_GAIN_P:             cfg_q.gain_p      <= wr_data[15:0];
				mspl_pkg::REG_GAIN_I:             cfg_q.gain_i      <= wr_data[15:0];
				mspl_pkg::REG_GAIN_D:             cfg_q.gain_d      <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- design/mspl_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mspl_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  mspl_pkg::cfg_t          cfg,
	input  mspl_pkg::dp_cmd_t       cmd,
	input  wire logic signed [23:0] in_speed,
	input  wire logic               in_invalid,
	output mspl_pkg::dp_stat_t      stat,
	output logic signed [23:0]      out_rpm,
	output logic [14:0]             out_duty,
	output logic [15:0]             out_drive,
	output logic [1:0]              out_health
);

	localparam int PW = mspl_pkg::PROD_W;

	// Item registers.
	logic signed [23:0]    omega_q;
	logic                  invalid_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [PW-1:0]  acc_q;
	logic signed [23:0]    rpm_q;
	logic signed [25:0]    err_q;
	logic signed [26:0]    diff_q;
	logic [16:0]           volts_q;
	logic [15:0]           drive_q;
	logic [1:0]            health_q;

	// Loop state carried from item to item.
	logic [15:0]           integ_q;
	logic signed [25:0]    prev_q;
	logic signed [31:0]    df_q;

	// Shared multiplier.
	logic                                mul_en;
	logic signed [mspl_pkg::MUL_A_W-1:0] mul_a;
	logic signed [mspl_pkg::MUL_B_W-1:0] mul_b;
	logic signed [PW-1:0]                mul_p;

	logic signed [PW-1:0]  rnd16;
	logic signed [PW-1:0]  dsum;
	logic signed [PW-1:0]  psum;
	logic signed [23:0]    rpm_next;
	logic signed [25:0]    err_next;
	logic signed [26:0]    diff_next;
	logic signed [25:0]    isum;
	logic [15:0]           integ_next;
	logic signed [31:0]    df_next;
	logic [16:0]           pid_next;
	logic signed [18:0]    vsum;
	logic [15:0]           drive_next;
	logic signed [25:0]    tdiff;
	logic signed [25:0]    tabs;
	logic [1:0]            health_next;
	logic [20:0]           cmd_scaled;
	logic [20:0]           drive_scaled;

	assign cmd_scaled   = 21'(cfg.command) * 21'd48 + 21'd12;
	assign drive_scaled = 21'(drive_q) * 21'd25 + 21'd24;

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (cmd.op)
			mspl_pkg::OP_RPM_MUL: begin
				mul_a = 33'(omega_q);
				mul_b = mspl_pkg::K_RPM;
			end
			mspl_pkg::OP_TGT_MUL: begin
				mul_a = 33'(cfg.tracked);
				mul_b = mspl_pkg::K_RAD;
			end
			mspl_pkg::OP_OPEN_MUL: begin
				mul_a = 33'(cmd_scaled);
				mul_b = mspl_pkg::K_DIV25;
			end
			mspl_pkg::OP_IINC_MUL: begin
				mul_a = 33'(err_q);
				mul_b = mspl_pkg::K_DT;
			end
			mspl_pkg::OP_DF1_MUL: begin
				mul_a = 33'(diff_q);
				mul_b = mspl_pkg::K_ALPHA_D;
			end
			mspl_pkg::OP_DF2_MUL: begin
				mul_a = 33'(df_q);
				mul_b = mspl_pkg::K_ALPHA_O;
			end
			mspl_pkg::OP_DFP_MUL: begin
				mul_a = 33'(err_q);
				mul_b = 24'(cfg.gain_p);
			end
			mspl_pkg::OP_I_MUL: begin
				mul_a = 33'(integ_q);
				mul_b = 24'(cfg.gain_i);
			end
			mspl_pkg::OP_D_MUL: begin
				mul_a = 33'(df_q);
				mul_b = 24'(cfg.gain_d);
			end
			mspl_pkg::OP_DUTY_MUL: begin
				mul_a = 33'(drive_scaled[20:4]);
				mul_b = mspl_pkg::K_DIV3;
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Round half up and drop 16 fraction bits of the last product.
	assign rnd16 = (prod_q + 57'sd32768) >>> 16;

	always_comb begin
		if (rnd16 > 57'sd8388607) begin
			rpm_next = 24'sh7FFFFF;
		end else if (rnd16 < -57'sd8388608) begin
			rpm_next = -24'sd8388608;
		end else begin
			rpm_next = rnd16[23:0];
		end
	end

	assign err_next  = $signed(rnd16[25:0]) - 26'(omega_q);
	assign diff_next = 27'(err_next) - 27'(prev_q);

	assign isum = $signed(rnd16[25:0]) + $signed({10'd0, integ_q});
	always_comb begin
		if (isum < 26'sd0) begin
			integ_next = '0;
		end else if (isum > 26'sd49152) begin
			integ_next = mspl_pkg::VOLT_MAX;
		end else begin
			integ_next = isum[15:0];
		end
	end

	// Filtered derivative: new and old terms, rounded, saturated to 32 bits.
	assign dsum = (acc_q + prod_q + 57'sd32768) >>> 16;
	always_comb begin
		if (dsum > 57'sd2147483647) begin
			df_next = 32'sh7FFFFFFF;
		end else if (dsum < -57'sd2147483648) begin
			df_next = 32'sh80000000;
		end else begin
			df_next = dsum[31:0];
		end
	end

	// PID sum: the derivative product is scaled by 16 before the final add.
	assign psum = (acc_q + (prod_q <<< 4) + 57'sd128) >>> 8;
	always_comb begin
		if (psum < 57'sd0) begin
			pid_next = '0;
		end else if (psum > 57'sd49152) begin
			pid_next = 17'(mspl_pkg::VOLT_MAX);
		end else begin
			pid_next = psum[16:0];
		end
	end

	assign vsum = $signed({2'b00, volts_q}) + 19'(cfg.offset);
	always_comb begin
		if (vsum < 19'sd0) begin
			drive_next = '0;
		end else if (vsum > 19'sd49152) begin
			drive_next = mspl_pkg::VOLT_MAX;
		end else begin
			drive_next = vsum[15:0];
		end
	end

	assign tdiff = $signed({6'd0, cfg.tracked}) - 26'(rpm_q);
	assign tabs  = (tdiff < 26'sd0) ? -tdiff : tdiff;

	always_comb begin
		priority if (invalid_q) begin
			health_next = mspl_pkg::HEALTH_FAULT;
		end else if (cfg.closed_loop) begin
			if ($unsigned(tabs) > mspl_pkg::ERR_FAULT) begin
				health_next = mspl_pkg::HEALTH_FAULT;
			end else if ($unsigned(tabs) > mspl_pkg::ERR_WARN) begin
				health_next = mspl_pkg::HEALTH_TRACK;
			end else begin
				health_next = mspl_pkg::HEALTH_NORMAL;
			end
		end else if (drive_next >= mspl_pkg::VOLT_NEAR_MAX &&
				cfg.command >= mspl_pkg::CMD_NEAR_MAX) begin
			health_next = mspl_pkg::HEALTH_FAULT;
		end else begin
			health_next = mspl_pkg::HEALTH_NORMAL;
		end
	end

	// Loop state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
			df_q    <= '0;
		end else begin
			unique case (cmd.op)
				mspl_pkg::OP_DF1_MUL: integ_q <= integ_next;
				mspl_pkg::OP_DFP_MUL: begin
					df_q   <= df_next;
					prev_q <= err_q;
				end
				mspl_pkg::OP_OPEN_VOLTS: begin
					integ_q <= '0;
					prev_q  <= '0;
					df_q    <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			omega_q   <= in_speed;
			invalid_q <= in_invalid;
		end
		if (mul_en) begin
			prod_q <= mul_p;
		end
		unique case (cmd.op)
			mspl_pkg::OP_TGT_MUL,
			mspl_pkg::OP_OPEN_MUL: rpm_q <= rpm_next;
			mspl_pkg::OP_ZERO: begin
				rpm_q   <= rpm_next;
				volts_q <= '0;
			end
			mspl_pkg::OP_ERR: begin
				err_q  <= err_next;
				diff_q <= diff_next;
			end
			mspl_pkg::OP_DF2_MUL:    acc_q   <= prod_q;
			mspl_pkg::OP_I_MUL:      acc_q   <= prod_q <<< 4;
			mspl_pkg::OP_D_MUL:      acc_q   <= acc_q + prod_q;
			mspl_pkg::OP_PID:        volts_q <= pid_next;
			mspl_pkg::OP_OPEN_VOLTS: volts_q <= prod_q[42:26];
			mspl_pkg::OP_DRIVE: begin
				drive_q  <= drive_next;
				health_q <= health_next;
			end
			default: begin
			end
		endcase
		if (cmd.load_out) begin
			out_rpm    <= invalid_q ? 24'sd0 : rpm_q;
			out_duty   <= prod_q[32:18];
			out_drive  <= drive_q;
			out_health <= health_q;
		end
	end

	assign stat.closed_loop = cfg.closed_loop;
	assign stat.invalid     = invalid_q;

endmodule

`default_nettype wire

// ----- design/mspl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mspl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  mspl_pkg::dp_stat_t stat,
	output mspl_pkg::dp_cmd_t  cmd
);

	mspl_pkg::ctl_state_t state_q;
	mspl_pkg::ctl_state_t state_next;
	logic                 out_valid_q;
	logic                 slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			mspl_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = mspl_pkg::ST_RPM;
				end
			end
			mspl_pkg::ST_RPM: begin
				priority if (stat.closed_loop && !stat.invalid) begin
					state_next = mspl_pkg::ST_TGT;
				end else if (stat.closed_loop) begin
					state_next = mspl_pkg::ST_ZERO;
				end else begin
					state_next = mspl_pkg::ST_OPEN;
				end
			end
			mspl_pkg::ST_TGT:    state_next = mspl_pkg::ST_ERR;
			mspl_pkg::ST_ERR:    state_next = mspl_pkg::ST_IINC;
			mspl_pkg::ST_IINC:   state_next = mspl_pkg::ST_DF1;
			mspl_pkg::ST_DF1:    state_next = mspl_pkg::ST_DF2;
			mspl_pkg::ST_DF2:    state_next = mspl_pkg::ST_DFP;
			mspl_pkg::ST_DFP:    state_next = mspl_pkg::ST_IMUL;
			mspl_pkg::ST_IMUL:   state_next = mspl_pkg::ST_DMUL;
			mspl_pkg::ST_DMUL:   state_next = mspl_pkg::ST_PID;
			mspl_pkg::ST_PID:    state_next = mspl_pkg::ST_DRIVE;
			mspl_pkg::ST_OPEN:   state_next = mspl_pkg::ST_OVOLTS;
			mspl_pkg::ST_OVOLTS: state_next = mspl_pkg::ST_DRIVE;
			mspl_pkg::ST_ZERO:   state_next = mspl_pkg::ST_DRIVE;
			mspl_pkg::ST_DRIVE:  state_next = mspl_pkg::ST_DUTY;
			mspl_pkg::ST_DUTY:   state_next = mspl_pkg::ST_FINISH;
			mspl_pkg::ST_FINISH: begin
				if (slot_free) begin
					state_next = mspl_pkg::ST_IDLE;
				end
			end
			default: state_next = mspl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == mspl_pkg::ST_IDLE);
		cmd.load_in  = in_ready && in_valid;
		cmd.load_out = (state_q == mspl_pkg::ST_FINISH) && slot_free;
		unique case (state_q)
			mspl_pkg::ST_RPM:    cmd.op = mspl_pkg::OP_RPM_MUL;
			mspl_pkg::ST_TGT:    cmd.op = mspl_pkg::OP_TGT_MUL;
			mspl_pkg::ST_OPEN:   cmd.op = mspl_pkg::OP_OPEN_MUL;
			mspl_pkg::ST_ZERO:   cmd.op = mspl_pkg::OP_ZERO;
			mspl_pkg::ST_ERR:    cmd.op = mspl_pkg::OP_ERR;
			mspl_pkg::ST_IINC:   cmd.op = mspl_pkg::OP_IINC_MUL;
			mspl_pkg::ST_DF1:    cmd.op = mspl_pkg::OP_DF1_MUL;
			mspl_pkg::ST_DF2:    cmd.op = mspl_pkg::OP_DF2_MUL;
			mspl_pkg::ST_DFP:    cmd.op = mspl_pkg::OP_DFP_MUL;
			mspl_pkg::ST_IMUL:   cmd.op = mspl_pkg::OP_I_MUL;
			mspl_pkg::ST_DMUL:   cmd.op = mspl_pkg::OP_D_MUL;
			mspl_pkg::ST_PID:    cmd.op = mspl_pkg::OP_PID;
			mspl_pkg::ST_OVOLTS: cmd.op = mspl_pkg::OP_OPEN_VOLTS;
			mspl_pkg::ST_DRIVE:  cmd.op = mspl_pkg::OP_DRIVE;
			mspl_pkg::ST_DUTY:   cmd.op = mspl_pkg::OP_DUTY_MUL;
			default:             cmd.op = mspl_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mspl_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- design/motor_speed_pid_loop_top.sv -----
// Motor speed control loop: one measured shaft speed in, one drive result out.
// Input beats arrive on the s_ group: s_tdata carries the signed speed in 1/16 rad/s
// and s_tuser flags the measurement as invalid. Each input beat yields exactly one
// output beat on the m_ group carrying speed in rpm, duty, drive voltage and health.
// The seven loop registers are written through the cfg_ port, which is always ready;
// they should only be changed while no item is in flight.
// One item is processed at a time by a sequencer around a single shared 33 x 24 bit
// multiplier with a registered product. A closed-loop item with a valid measurement
// runs the longest sequence of states, through the error, integrator, derivative filter
// and PID steps; an open-loop item or an invalid closed-loop item takes a shorter path.
// The sequencer returns to idle between items and takes no new beat until it is there.
// The chain of dependent multiplications of a closed-loop step makes its path the longest.
// A finished result sits in the output register, so a new input beat is taken while it
// waits; if the receiver stalls, the next result waits in the sequencer until the
// output register empties, and input is held off meanwhile.
// Reset clears the configuration, the integrator, the previous error and the filtered
// derivative to zero, and leaves both channels empty.
`timescale 1ns / 1ps
`default_nettype none

module motor_speed_pid_loop_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Input stream.
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [23:0]                     s_tdata,  // [23:0] shaft_speed
	input  wire logic                            s_tuser,  // [0] speed_invalid
	// Output stream.
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [23:0] speed_rpm, [38:24] duty_percent, [54:39] drive_voltage,
	// [56:55] health_status, [63:57] zero
	output logic [63:0]                          m_tdata,
	// Configuration writes.
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [mspl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mspl_pkg::CFG_DATA_W-1:0] cfg_data
);

	mspl_pkg::cfg_t     cfg;
	mspl_pkg::dp_cmd_t  cmd;
	mspl_pkg::dp_stat_t stat;

	logic signed [23:0] out_rpm;
	logic [14:0]        out_duty;
	logic [15:0]        out_drive;
	logic [1:0]         out_health;

	// Register writes complete in the beat they are offered.
	assign cfg_ready = 1'b1;

	mspl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	mspl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mspl_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.in_speed   ($signed(s_tdata)),
		.in_invalid (s_tuser),
		.stat       (stat),
		.out_rpm    (out_rpm),
		.out_duty   (out_duty),
		.out_drive  (out_drive),
		.out_health (out_health)
	);

	assign m_tdata = {7'd0, out_health, out_drive, out_duty, out_rpm};

	// The sequencer is busy after taking a beat, so input is not ready straight after it.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is still in work");

	// The drive voltage never leaves the 0 to 12 V range.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_drive <= mspl_pkg::VOLT_MAX)
		else $error("drive voltage above full scale");

	// Duty follows the clamped drive and stays within 100 percent.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_duty <= mspl_pkg::DUTY_MAX)
		else $error("duty above 100 percent");

	// An invalid measurement always reports a fault and a zero speed.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && stat.invalid |=> out_health == mspl_pkg::HEALTH_FAULT && out_rpm == 24'sd0)
		else $error("invalid measurement not reported as fault");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the motor speed control loop.
// Speed measurements are sent as beats on the s_ stream. Each accepted beat is run
// through a predictor of the loop kept in this file. The predictor has its own copy of
// the seven loop registers and of the integrator, the previous error and the filtered
// derivative. Every result beat on the m_ stream is then checked, field by field,
// against the oldest prediction still waiting.
// A short directed part covers the extremes of speed, invalid measurements in both
// modes, the open-loop saturation band and out-of-range commands and offsets. Random
// phases follow, each with fresh register settings. Their speeds stay mostly close to
// the set point, so the integrator and the derivative filter work in range.
// The register values also carry stray upper bits now and then.
module tb_top;
	import mspl_pkg::*;

	localparam longint RPM_SCALE     = 39114;    // rad/s to rpm, over 2^16
	localparam longint RAD_SCALE     = 109807;   // rpm to rad/s, over 2^16
	localparam longint DT_SCALE      = 10486;    // 0.01 s, over 2^16
	localparam longint ALPHA_NEW     = 9830;     // weight of the new derivative
	localparam longint ALPHA_OLD     = 55706;    // weight of the filtered derivative
	localparam longint VOLT_CEIL     = 49152;    // 12 V in 1/4096 V
	localparam longint SPEED_MIN     = -8388608;
	localparam longint SPEED_MAX     = 8388607;
	localparam longint FILT_MIN      = -64'sd2147483648;
	localparam longint FILT_MAX      = 64'sd2147483647;
	localparam longint CMD_TOP_BAND  = 25575;    // commands from here up may saturate
	localparam longint RPM_FAULT_GAP = 16000;
	localparam longint RPM_WARN_GAP  = 1600;

	// An index outside the register map. Writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam int IDLE_GUARD     = 20;    // cycles of quiet before a register write
	localparam int LONG_HOLD      = 300;   // the long stall of the receiver
	localparam int WATCHDOG_LIMIT = 2000;  // cycles without any beat before giving up
	localparam int PHASES         = 30;
	localparam int PHASE_ITEMS    = 54;

	typedef struct {
		logic [23:0] shaft_speed;
		logic        invalid;
	} speed_beat_t;

	// Layout of m_tdata, from the top bit down.
	typedef struct packed {
		logic [6:0]  padding;
		logic [1:0]  health;
		logic [15:0] drive_volts;
		logic [14:0] duty;
		logic [23:0] speed_rpm;
	} drive_result_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [63:0]           m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Handshakes seen at the last rising edge. The falling-edge drivers read these.
	logic speed_taken  = 1'b0;
	logic result_taken = 1'b0;
	logic cfg_taken    = 1'b0;

	speed_beat_t   pending_speeds[$];
	drive_result_t drive_results_due[$];

	int   in_gap_max     = 17;
	int   out_gap_max    = 17;
	int   send_gap       = 0;
	int   ready_hold     = 0;
	logic long_hold_req  = 1'b0;
	logic long_hold_done = 1'b0;
	int   quiet_cycles   = 0;
	int   fail_count     = 0;

	// The predictor's own copy of the loop registers and of the loop state.
	logic               loop_closed    = 1'b0;
	logic [19:0]        speed_setpoint = '0;
	logic [14:0]        duty_command   = '0;
	logic signed [16:0] bias_volts     = '0;
	logic [15:0]        kp             = '0;
	logic [15:0]        ki             = '0;
	logic [15:0]        kd             = '0;
	longint             integ_acc      = 0;
	longint             last_error     = 0;
	longint             deriv_smooth   = 0;

	motor_speed_pid_loop_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Round half up: floor((v + 2^(sh-1)) / 2^sh). The arithmetic shift floors.
	function automatic longint round_off(longint v, int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint limit(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// One loop step. The state is updated here, so call it once per accepted beat.
	function automatic drive_result_t predict_drive(logic signed [23:0] speed, logic invalid);
		drive_result_t res;
		longint omega, rpm, volts, drive, target, err, deriv, sum, miss;
		omega = speed;
		rpm   = limit(round_off(omega * RPM_SCALE, 16), SPEED_MIN, SPEED_MAX);
		volts = 0;
		res.padding = '0;
		res.health  = HEALTH_NORMAL;
		if (loop_closed) begin
			// An invalid measurement freezes the PID state and contributes no voltage.
			if (!invalid) begin
				target = round_off(longint'(speed_setpoint) * RAD_SCALE, 16);
				err    = target - omega;
				deriv  = (err - last_error) * 100;
				integ_acc = limit(integ_acc + round_off(err * DT_SCALE, 16), 0, VOLT_CEIL);
				deriv_smooth = limit(round_off(deriv * ALPHA_NEW + deriv_smooth * ALPHA_OLD, 16),
					FILT_MIN, FILT_MAX);
				last_error = err;
				sum = longint'(kp) * err * 16 + longint'(ki) * integ_acc
					+ longint'(kd) * deriv_smooth * 16;
				volts = limit(round_off(sum, 8), 0, VOLT_CEIL);
			end
		end else begin
			integ_acc    = 0;
			last_error   = 0;
			deriv_smooth = 0;
			volts = (longint'(duty_command) * 48 + 12) / 25;
		end
		drive = limit(volts + longint'(bias_volts), 0, VOLT_CEIL);
		if (invalid) begin
			res.health = HEALTH_FAULT;
			rpm = 0;
		end else if (loop_closed) begin
			miss = longint'(speed_setpoint) - rpm;
			if (miss < 0)
				miss = -miss;
			if (miss > RPM_FAULT_GAP)
				res.health = HEALTH_FAULT;
			else if (miss > RPM_WARN_GAP)
				res.health = HEALTH_TRACK;
		end else if (drive * 1000 >= 999 * VOLT_CEIL && duty_command >= CMD_TOP_BAND) begin
			res.health = HEALTH_FAULT;
		end
		res.speed_rpm   = rpm[23:0];
		res.drive_volts = drive[15:0];
		res.duty        = 15'((drive * 25 + 24) / 48);
		return res;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Monitor and scoreboard. All outputs are sampled at the rising edge, before the
	// block's own updates for that edge take effect.
	always @(posedge clk) begin
		drive_result_t seen, want;
		speed_taken  <= s_tvalid && s_tready;
		result_taken <= m_tvalid && m_tready;
		cfg_taken    <= cfg_valid && cfg_ready;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CLOSED_LOOP_ENABLE: loop_closed    = cfg_data[0];
				REG_TRACKED_SPEED_RPM:  speed_setpoint = cfg_data[19:0];
				REG_OPEN_LOOP_COMMAND:  duty_command   = cfg_data[14:0];
				REG_VOLTAGE_OFFSET:     bias_volts     = cfg_data[16:0];
				REG_GAIN_P:             kp             = cfg_data[15:0];
				REG_GAIN_I:             ki             = cfg_data[15:0];
				REG_GAIN_D:             kd             = cfg_data[15:0];
				default: ;
			endcase
		end
		// The result beat is checked before a new prediction is queued. A result is registered
		// only after its own beat was taken, so the two can never concern the same measurement.
		if (m_tvalid && m_tready) begin
			seen = m_tdata;
			if (drive_results_due.size() == 0) begin
				$error("result beat with no prediction waiting: %h", m_tdata);
				fail_count++;
			end else begin
				want = drive_results_due.pop_front();
				check_field("speed_rpm", $signed(want.speed_rpm), $signed(seen.speed_rpm));
				check_field("duty_percent", want.duty, seen.duty);
				check_field("drive_voltage", want.drive_volts, seen.drive_volts);
				check_field("health_status", want.health, seen.health);
				check_field("padding", want.padding, seen.padding);
			end
		end
		if (s_tvalid && s_tready)
			drive_results_due.push_back(predict_drive(s_tdata, s_tuser));
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("motor_speed_pid_loop_top verification failed");
			$finish;
		end
	end

	// Sender. A beat stays on the bus until it is taken; after each taken beat a random gap,
	// bounded by in_gap_max, is drawn. Valid is worked out first and assigned once, so a
	// back-to-back beat never sees valid lowered and raised in the same step.
	always @(negedge clk) begin
		speed_beat_t beat;
		int          gap;
		logic        valid_next;
		if (arst_n) begin
			valid_next = s_tvalid;
			gap        = send_gap;
			if (s_tvalid && speed_taken) begin
				valid_next = 1'b0;
				gap = $urandom_range(0, in_gap_max);
			end
			if (!valid_next) begin
				if (gap > 0) begin
					gap--;
				end else if (pending_speeds.size() != 0) begin
					beat = pending_speeds.pop_front();
					s_tdata <= beat.shaft_speed;
					s_tuser <= beat.invalid;
					valid_next = 1'b1;
				end
			end
			send_gap <= gap;
			s_tvalid <= valid_next;
		end
	end

	// Receiver. After each taken result it stalls for a random hold bounded by out_gap_max.
	// Once, on request, it stalls for the LONG_HOLD span so that the block backs up and
	// holds off its input.
	always @(negedge clk) begin
		int hold;
		if (arst_n) begin
			hold = ready_hold;
			if (long_hold_req && !long_hold_done) begin
				hold = LONG_HOLD;
				long_hold_done <= 1'b1;
			end else if (result_taken) begin
				hold = $urandom_range(0, out_gap_max);
			end else if (hold > 0) begin
				hold--;
			end
			ready_hold <= hold;
			m_tready   <= (hold == 0);
		end
	end

	task automatic queue_speed(logic [23:0] speed, logic invalid);
		speed_beat_t beat;
		beat.shaft_speed = speed;
		beat.invalid     = invalid;
		pending_speeds.push_back(beat);
	endtask

	// Waits until every queued beat has been sent and every result has arrived, then
	// lets the sequencer run out before anything is reprogrammed.
	task automatic settle();
		while (pending_speeds.size() != 0 || s_tvalid || drive_results_due.size() != 0)
			@(posedge clk);
		repeat (IDLE_GUARD) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_loop(int closed, int tracked, int command, int offset,
		int gain_p_v, int gain_i_v, int gain_d_v);
		write_reg(REG_CLOSED_LOOP_ENABLE, 20'(closed));
		write_reg(REG_TRACKED_SPEED_RPM, 20'(tracked));
		write_reg(REG_OPEN_LOOP_COMMAND, 20'(command));
		write_reg(REG_VOLTAGE_OFFSET, 20'(offset));
		write_reg(REG_GAIN_P, 20'(gain_p_v));
		write_reg(REG_GAIN_I, 20'(gain_i_v));
		write_reg(REG_GAIN_D, 20'(gain_d_v));
	endtask

	// Now and then sets the bits above a register's width, which the block must drop.
	function automatic int noisy(int value, int width);
		int upper;
		upper = ($urandom_range(0, 3) == 0) ? (int'($urandom) << width) : 0;
		return (value & ((1 << width) - 1)) | upper;
	endfunction

	function automatic int pick_gain();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 65535;
			2:       return $urandom_range(0, 65535);
			default: return $urandom_range(0, 1023);
		endcase
	endfunction

	// One random phase: fresh registers, then a run of measurements. Most speeds lie
	// close to the set point so the loop tracks. The others are steps, noise, invalid
	// readings and the extremes.
	task automatic random_phase(int count, logic long_stall);
		int     closed, tracked, command, offset, spread, target, k, n;
		longint speed;
		logic   invalid;
		settle();
		closed = ($urandom_range(0, 3) != 0);
		case ($urandom_range(0, 3))
			0:       tracked = 0;
			1:       tracked = 20'hFFFFF;
			2:       tracked = $urandom_range(0, 20'hFFFFF);
			default: tracked = $urandom_range(0, 60000);
		endcase
		case ($urandom_range(0, 5))
			0:       command = 0;
			1:       command = 25600;
			2:       command = CMD_TOP_BAND;
			3:       command = 32767;
			4:       command = $urandom_range(0, 32767);
			default: command = $urandom_range(0, 25600);
		endcase
		case ($urandom_range(0, 5))
			0:       offset = 0;
			1:       offset = -49152;
			2:       offset = 49152;
			3:       offset = $urandom_range(0, 131071);
			default: offset = int'($urandom_range(0, 8192)) - 4096;
		endcase
		case ($urandom_range(0, 2))
			0:       spread = 64;
			1:       spread = 1024;
			default: spread = 8192;
		endcase
		program_loop(noisy(closed, 1), tracked, noisy(command, 15), noisy(offset, 17),
			noisy(pick_gain(), 16), noisy(pick_gain(), 16), noisy(pick_gain(), 16));
		// A third of the phases run with no idling on one side or the other.
		in_gap_max  = (long_stall || $urandom_range(0, 2) == 0) ? 0 : 17;
		out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
		long_hold_req = long_stall;
		target = int'(round_off(longint'(tracked) * RAD_SCALE, 16));
		for (n = 0; n < count; n++) begin
			k = $urandom_range(0, 99);
			invalid = 1'b0;
			if (k < 60) begin
				speed = target + int'($urandom_range(0, 2 * spread)) - spread;
			end else if (k < 75) begin
				speed = target + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 400000));
			end else if (k < 88) begin
				speed = $signed(24'($urandom));
			end else if (k < 95) begin
				speed = $signed(24'($urandom));
				invalid = 1'b1;
			end else begin
				case ($urandom_range(0, 2))
					0:       speed = SPEED_MIN;
					1:       speed = SPEED_MAX;
					default: speed = 0;
				endcase
			end
			queue_speed(24'(limit(speed, SPEED_MIN, SPEED_MAX)), invalid);
		end
	endtask

	initial begin
		int ph;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Registers at their reset values: open loop with no command, so the drive
		// stays at zero whatever the speed. Speed extremes and invalid readings.
		queue_speed(24'sd0, 1'b0);
		queue_speed(24'h7FFFFF, 1'b0);
		queue_speed(24'h800000, 1'b0);
		queue_speed(24'hFFFFFF, 1'b0);
		queue_speed(24'sd1, 1'b0);
		queue_speed(24'h800000, 1'b1);
		queue_speed(24'h7FFFFF, 1'b1);

		// Full open-loop command: the drive saturates and the status reports a fault.
		// A write to an unmapped index goes alongside and must leave the loop alone.
		settle();
		program_loop(0, 0, 25600, 0, 0, 0, 0);
		write_reg(REG_UNUSED, 20'hFFFFF);
		queue_speed(24'sd1000, 1'b0);
		queue_speed(24'sd0, 1'b1);

		// A command above full scale and the largest positive offset.
		settle();
		program_loop(0, 0, 32767, 65535, 0, 0, 0);
		queue_speed(24'sd500, 1'b0);

		// The lowest command of the saturation band, with the drive just on its threshold.
		settle();
		program_loop(0, 0, 25575, -1, 0, 0, 0);
		queue_speed(24'sd0, 1'b0);

		// Just below the saturation band.
		settle();
		program_loop(0, 0, 25574, 0, 0, 0, 0);
		queue_speed(24'sd0, 1'b0);

		// The most negative offset pulls the drive to zero.
		settle();
		program_loop(0, 0, 0, -65536, 0, 0, 0);
		queue_speed(24'sd0, 1'b0);

		// Closed loop with every gain at its top and the highest set point: large errors,
		// a saturating derivative filter and an invalid reading mid-run.
		settle();
		program_loop(1, 20'hFFFFF, 0, 49152, 65535, 65535, 65535);
		queue_speed(24'sd0, 1'b0);
		queue_speed(24'h7FFFFF, 1'b0);
		queue_speed(24'h800000, 1'b0);
		queue_speed(24'sd0, 1'b1);
		queue_speed(24'h800000, 1'b0);

		// Closed loop, set point zero, unit gains, an offset of minus full scale (-12 V).
		settle();
		program_loop(1, 0, 0, -49152, 256, 256, 256);
		queue_speed(24'h7FFFFF, 1'b0);
		queue_speed(24'h800000, 1'b0);
		queue_speed(24'sd0, 1'b0);
		queue_speed(24'sd0, 1'b1);

		// Random phases. The fourth one carries the long receiver stall.
		for (ph = 0; ph < PHASES; ph++)
			random_phase(PHASE_ITEMS, ph == 3);

		settle();
		if (fail_count == 0)
			$display("motor_speed_pid_loop_top verification clean");
		else
			$display("motor_speed_pid_loop_top verification failed");
		$finish;
	end

endmodule

// ----- motor_speed_pid_loop_top.f -----
design/mspl_pkg.sv
design/mspl_cfg.sv
design/mspl_datapath.sv
design/mspl_ctrl.sv
design/motor_speed_pid_loop_top.sv
tb/tb_top.sv
